>>> rtl/chbr_pkg.sv
// ----------------------------------------------------------------------------
// chbr_pkg
// Shared widths, codes and types of the channel block remap block.
// ----------------------------------------------------------------------------
package chbr_pkg;

  // Frame geometry
  localparam int FRAME_CHANNELS = 4096;
  localparam int FRAME_AW       = $clog2(FRAME_CHANNELS);

  // Field widths
  localparam int ACTION_W = 2;
  localparam int INDEX_W  = 12;
  localparam int CH_W     = 8;
  localparam int START_W  = 12;
  localparam int CNT_W    = 13;
  localparam int MODE_W   = 2;

  // Scratch holds one whole block of up to 2**CNT_W - 1 bytes
  localparam int SCRATCH_DEPTH = 1 << CNT_W;
  localparam int SCRATCH_AW    = CNT_W;

  // Working channel address: a start plus a block offset, beyond the frame end
  localparam int WORK_AW = ((FRAME_AW > CNT_W) ? FRAME_AW : CNT_W) + 1;

  // Pixel sizes of the pixel reverse modes
  localparam int RGB_PX  = 3;
  localparam int RGBW_PX = 4;

  // Configuration port
  localparam int PADDR_W = 5;
  localparam int APB_DW  = 32;

  typedef enum logic [ACTION_W-1:0] {
    ACT_WRITE = 2'd0,
    ACT_READ  = 2'd1,
    ACT_APPLY = 2'd2
  } action_t;

  typedef enum logic [MODE_W-1:0] {
    MODE_PLAIN = 2'd0,
    MODE_BYTE  = 2'd1,
    MODE_RGB   = 2'd2,
    MODE_RGBW  = 2'd3
  } mode_t;

  typedef enum logic [PADDR_W-3:0] {
    REG_SOURCE_START = 3'd0,
    REG_DEST_START   = 3'd1,
    REG_BLOCK_COUNT  = 3'd2,
    REG_REPEAT_LOOPS = 3'd3,
    REG_REVERSE_MODE = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic [START_W-1:0] source_start;
    logic [START_W-1:0] dest_start;
    logic [CNT_W-1:0]   block_count;
    logic [CNT_W-1:0]   repeat_loops;
    mode_t              reverse_mode;
  } cfg_t;

  typedef struct packed {
    logic                we;
    logic [FRAME_AW-1:0] addr;
    logic [CH_W-1:0]     data;
  } frame_wr_t;

  typedef struct packed {
    logic                  we;
    logic [SCRATCH_AW-1:0] addr;
    logic [CH_W-1:0]       data;
  } scratch_wr_t;

endpackage

>>> rtl/chbr_cmd_if.sv
// ----------------------------------------------------------------------------
// chbr_cmd_if
// Command channel: write, read and apply items with valid/ready handshake.
// ----------------------------------------------------------------------------
interface chbr_cmd_if import chbr_pkg::*; ();

  logic                valid;
  logic                ready;
  logic [ACTION_W-1:0] action;
  logic [INDEX_W-1:0]  channel_index;
  logic [CH_W-1:0]     channel_value;

  modport source (output valid, action, channel_index, channel_value, input ready);
  modport sink   (input valid, action, channel_index, channel_value, output ready);

endinterface

>>> rtl/chbr_rsp_if.sv
// ----------------------------------------------------------------------------
// chbr_rsp_if
// Response channel: one result item per command item.
// ----------------------------------------------------------------------------
interface chbr_rsp_if import chbr_pkg::*; ();

  logic            valid;
  logic            ready;
  logic [CH_W-1:0] read_value;
  logic            clipped;

  modport source (output valid, read_value, clipped, input ready);
  modport sink   (input valid, read_value, clipped, output ready);

endinterface

>>> rtl/chbr_ram.sv
// ----------------------------------------------------------------------------
// chbr_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module chbr_ram #(
  parameter int  WIDTH = 8,
  parameter int  DEPTH = 4096,
  localparam int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/chbr_cfg.sv
// ----------------------------------------------------------------------------
// chbr_cfg
// APB register file holding the remap configuration.
// ----------------------------------------------------------------------------
module chbr_cfg import chbr_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [APB_DW-1:0]  pwdata,
  output logic [APB_DW-1:0]  prdata,
  output logic               pready,
  output cfg_t               cfg
);

  logic     wr_en;
  reg_idx_t reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_sel = reg_idx_t'(paddr[PADDR_W-1:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.source_start <= '0;
      cfg.dest_start   <= '0;
      cfg.block_count  <= CNT_W'(1);
      cfg.repeat_loops <= CNT_W'(1);
      cfg.reverse_mode <= MODE_PLAIN;
    end else if (wr_en) begin
      case (reg_sel)
        REG_SOURCE_START: cfg.source_start <= pwdata[START_W-1:0];
        REG_DEST_START:   cfg.dest_start   <= pwdata[START_W-1:0];
        REG_BLOCK_COUNT:  cfg.block_count  <= pwdata[CNT_W-1:0];
        REG_REPEAT_LOOPS: cfg.repeat_loops <= pwdata[CNT_W-1:0];
        REG_REVERSE_MODE: cfg.reverse_mode <= mode_t'(pwdata[MODE_W-1:0]);
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (reg_sel)
      REG_SOURCE_START: prdata = APB_DW'(cfg.source_start);
      REG_DEST_START:   prdata = APB_DW'(cfg.dest_start);
      REG_BLOCK_COUNT:  prdata = APB_DW'(cfg.block_count);
      REG_REPEAT_LOOPS: prdata = APB_DW'(cfg.repeat_loops);
      REG_REVERSE_MODE: prdata = APB_DW'(cfg.reverse_mode);
      default:          prdata = '0;
    endcase
  end

endmodule

>>> rtl/chbr_seq.sv
// ----------------------------------------------------------------------------
// chbr_seq
// Item sequencer: clearing pass, byte access and the block copy engine that
// streams bytes between the frame and the scratch RAM one per cycle.
// ----------------------------------------------------------------------------
module chbr_seq import chbr_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  cfg_t                  cfg,
  chbr_cmd_if.sink              cmd,
  chbr_rsp_if.source            rsp,
  output frame_wr_t             frame_wr,
  output logic [FRAME_AW-1:0]   frame_raddr,
  input  logic [CH_W-1:0]       frame_rdata,
  output scratch_wr_t           scratch_wr,
  output logic [SCRATCH_AW-1:0] scratch_raddr,
  input  logic [CH_W-1:0]       scratch_rdata
);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_READ, S_LOOP, S_SNAP, S_SNAP_END, S_WR, S_WR_END, S_FINISH
  } state_t;

  // Which copy of an apply is in flight
  typedef enum logic [1:0] {PH_PLAIN, PH_REV_SRC, PH_REV_DST, PH_REPEAT} phase_t;

  // Scratch read order of a block write
  typedef enum logic [1:0] {WK_FWD, WK_REV, WK_PIX} wkind_t;

  localparam logic [WORK_AW-1:0] FRAME_END = WORK_AW'(FRAME_CHANNELS);

  state_t              state;
  phase_t              phase;
  wkind_t              wkind;
  logic [FRAME_AW-1:0] clr_addr;
  logic [CNT_W-1:0]    cnt;
  logic [CNT_W-1:0]    loops_left;
  logic [WORK_AW-1:0]  base;
  logic [WORK_AW-1:0]  ptr;
  logic [CNT_W-1:0]    idx;
  logic [CNT_W:0]      rptr;
  logic [2:0]          px;
  logic [1:0]          k;
  logic                clip;
  logic                rd_zero;
  logic [CH_W-1:0]     res_value;
  logic                dw_valid;
  logic [FRAME_AW-1:0] dw_addr;
  logic                ds_valid;
  logic                ds_zero;
  logic [SCRATCH_AW-1:0] ds_addr;
  logic                out_valid;
  logic [CH_W-1:0]     out_value;
  logic                out_clip;

  logic                accept;
  logic                res_load;
  logic [WORK_AW-1:0]  idx_w;
  logic                idx_in_frame;
  logic [CNT_W-1:0]    cnt_eff;
  logic [WORK_AW-1:0]  src_w;
  logic [WORK_AW-1:0]  dst_w;
  logic [2:0]          px_cfg;
  logic [3:0]          pix_back;
  logic [CNT_W:0]      pix_next;
  logic                ptr_out;

  assign cmd.ready      = (state == S_IDLE);
  assign accept         = cmd.valid && cmd.ready;
  assign res_load       = (state == S_FINISH) && (!out_valid || rsp.ready);
  assign idx_w          = WORK_AW'(cmd.channel_index);
  assign idx_in_frame   = (idx_w < FRAME_END);
  assign cnt_eff        = (cfg.block_count == '0) ? CNT_W'(1) : cfg.block_count;
  assign src_w          = WORK_AW'(cfg.source_start);
  assign dst_w          = WORK_AW'(cfg.dest_start);
  assign px_cfg         = (cfg.reverse_mode == MODE_RGB) ? 3'(RGB_PX) : 3'(RGBW_PX);
  assign pix_back       = {px, 1'b0} - 4'd1;
  assign pix_next       = rptr - (CNT_W+1)'(pix_back);
  assign ptr_out        = (ptr >= FRAME_END);

  assign rsp.valid      = out_valid;
  assign rsp.read_value = out_value;
  assign rsp.clipped    = out_clip;

  // RAM ports
  always_comb begin
    frame_wr      = '0;
    frame_raddr   = idx_w[FRAME_AW-1:0];
    if (state == S_CLEAR) begin
      frame_wr.we   = 1'b1;
      frame_wr.addr = clr_addr;
    end else if (dw_valid) begin
      frame_wr.we   = 1'b1;
      frame_wr.addr = dw_addr;
      frame_wr.data = scratch_rdata;
    end else if (accept && action_t'(cmd.action) == ACT_WRITE && idx_in_frame) begin
      frame_wr.we   = 1'b1;
      frame_wr.addr = idx_w[FRAME_AW-1:0];
      frame_wr.data = cmd.channel_value;
    end
    if (state == S_SNAP) begin
      frame_raddr = ptr[FRAME_AW-1:0];
    end
    scratch_wr.we   = ds_valid;
    scratch_wr.addr = ds_addr;
    scratch_wr.data = ds_zero ? '0 : frame_rdata;
    scratch_raddr   = rptr[SCRATCH_AW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_addr  <= '0;
      clip      <= 1'b0;
      dw_valid  <= 1'b0;
      ds_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (res_load) begin
        out_valid <= 1'b1;
      end else if (rsp.valid && rsp.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + FRAME_AW'(1);
          if (clr_addr == FRAME_AW'(FRAME_CHANNELS - 1)) begin
            state <= S_IDLE;
          end
        end

        S_IDLE: begin
          if (accept) begin
            res_value <= '0;
            clip      <= 1'b0;
            rd_zero   <= !idx_in_frame;
            cnt       <= cnt_eff;
            px        <= px_cfg;
            case (action_t'(cmd.action))
              ACT_READ: state <= S_READ;
              ACT_APPLY: begin
                if (cfg.repeat_loops == '0) begin
                  state <= S_FINISH;
                end else if (cfg.reverse_mode != MODE_PLAIN && cnt_eff > CNT_W'(1)) begin
                  // Reverse: snapshot the source first, later loops go from dest
                  phase      <= PH_REV_SRC;
                  loops_left <= cfg.repeat_loops - CNT_W'(1);
                  base       <= dst_w + WORK_AW'(cnt_eff);
                  ptr        <= src_w;
                  idx        <= '0;
                  state      <= S_SNAP;
                end else begin
                  phase      <= PH_PLAIN;
                  loops_left <= cfg.repeat_loops;
                  base       <= dst_w;
                  state      <= S_LOOP;
                end
              end
              default: state <= S_FINISH;
            endcase
          end
        end

        S_READ: begin
          res_value <= rd_zero ? '0 : frame_rdata;
          state     <= S_FINISH;
        end

        S_LOOP: begin
          if (loops_left == '0) begin
            state <= S_FINISH;
          end else if (base >= FRAME_END) begin
            clip  <= 1'b1;
            state <= S_FINISH;
          end else if (phase == PH_PLAIN) begin
            ptr   <= src_w;
            idx   <= '0;
            state <= S_SNAP;
          end else begin
            wkind <= WK_FWD;
            ptr   <= base;
            idx   <= '0;
            rptr  <= '0;
            state <= S_WR;
          end
        end

        S_SNAP: begin
          ds_valid <= 1'b1;
          ds_addr  <= idx;
          ds_zero  <= ptr_out;
          ptr      <= ptr + WORK_AW'(1);
          idx      <= idx + CNT_W'(1);
          if (idx == cnt - CNT_W'(1)) begin
            state <= S_SNAP_END;
          end
        end

        S_SNAP_END: begin
          ds_valid <= 1'b0;
          idx      <= '0;
          case (phase)
            PH_REV_SRC: begin
              ptr <= dst_w;
              if (cfg.reverse_mode == MODE_BYTE) begin
                wkind <= WK_REV;
                rptr  <= {1'b0, cnt - CNT_W'(1)};
                state <= S_WR;
              end else begin
                // Start at the last full pixel; skip when no pixel fits
                wkind <= WK_PIX;
                k     <= '0;
                rptr  <= {1'b0, cnt} - (CNT_W+1)'(px);
                state <= (cnt < CNT_W'(px)) ? S_WR_END : S_WR;
              end
            end
            PH_REV_DST: begin
              phase <= PH_REPEAT;
              state <= S_LOOP;
            end
            default: begin
              wkind <= WK_FWD;
              ptr   <= base;
              rptr  <= '0;
              state <= S_WR;
            end
          endcase
        end

        S_WR: begin
          if (ptr_out) begin
            // Everything from here on lands past the frame end
            clip     <= 1'b1;
            dw_valid <= 1'b0;
            state    <= S_WR_END;
          end else begin
            dw_valid <= 1'b1;
            dw_addr  <= ptr[FRAME_AW-1:0];
            ptr      <= ptr + WORK_AW'(1);
            idx      <= idx + CNT_W'(1);
            case (wkind)
              WK_FWD: begin
                rptr <= rptr + (CNT_W+1)'(1);
                if (idx == cnt - CNT_W'(1)) state <= S_WR_END;
              end
              WK_REV: begin
                rptr <= rptr - (CNT_W+1)'(1);
                if (idx == cnt - CNT_W'(1)) state <= S_WR_END;
              end
              default: begin
                if ({1'b0, k} == px - 3'd1) begin
                  k    <= '0;
                  rptr <= pix_next;
                  if (pix_next[CNT_W]) state <= S_WR_END;
                end else begin
                  k    <= k + 2'd1;
                  rptr <= rptr + (CNT_W+1)'(1);
                end
              end
            endcase
          end
        end

        S_WR_END: begin
          dw_valid <= 1'b0;
          if (clip) begin
            state <= S_FINISH;
          end else if (phase == PH_REV_SRC) begin
            phase <= PH_REV_DST;
            ptr   <= dst_w;
            idx   <= '0;
            state <= S_SNAP;
          end else begin
            loops_left <= loops_left - CNT_W'(1);
            base       <= base + WORK_AW'(cnt);
            state      <= S_LOOP;
          end
        end

        S_FINISH: begin
          // Hold the result until the output register is free
          if (res_load) begin
            out_value <= res_value;
            out_clip  <= clip;
            state     <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_clear_after_reset: assert property (@(posedge clk) disable iff (rst)
    $fell(rst) |-> state == S_CLEAR)
    else $error("clearing pass not started after reset");

  a_one_stream: assert property (@(posedge clk) disable iff (rst)
    dw_valid |-> !ds_valid)
    else $error("snapshot and block write in flight together");

  a_snap_in_block: assert property (@(posedge clk) disable iff (rst)
    state == S_SNAP |-> idx < cnt)
    else $error("snapshot ran past the block");

  a_scratch_ptr: assert property (@(posedge clk) disable iff (rst)
    state == S_WR && !ptr_out |-> !rptr[CNT_W])
    else $error("scratch read pointer below zero");

  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    state == S_FINISH && rsp.valid && !rsp.ready |=> state == S_FINISH)
    else $error("result dropped while output stalled");
`endif

endmodule

>>> rtl/channel_block_remap.sv
// ----------------------------------------------------------------------------
// channel_block_remap
// Frame of 8-bit lighting channels with byte access and block remap.
// ----------------------------------------------------------------------------
// After reset the block clears the frame RAM and takes no item until done;
// configuration writes are taken throughout. One item is worked at a time,
// and its result goes to an output register so the next item is taken while
// that result waits. A write item goes from idle straight to its result; a
// read item first passes a read state for the registered frame RAM read. An
// apply streams one byte per cycle through the single frame RAM port pair and
// a block-sized scratch RAM. In plain mode each copy is a snapshot pass of
// count bytes and a write pass of up to count bytes, plus loop control; the
// reverse modes snapshot the source, write it reversed, snapshot that dest
// block, and every further loop is a write pass only. An apply stops at the
// first write that falls past the frame end.
module channel_block_remap import chbr_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  chbr_cmd_if.sink           cmd,
  chbr_rsp_if.source         rsp,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [APB_DW-1:0]  pwdata,
  output logic [APB_DW-1:0]  prdata,
  output logic               pready
);

  cfg_t                  cfg;
  frame_wr_t             frame_wr;
  logic [FRAME_AW-1:0]   frame_raddr;
  logic [CH_W-1:0]       frame_rdata;
  scratch_wr_t           scratch_wr;
  logic [SCRATCH_AW-1:0] scratch_raddr;
  logic [CH_W-1:0]       scratch_rdata;

  chbr_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  chbr_seq u_seq (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .cmd           (cmd),
    .rsp           (rsp),
    .frame_wr      (frame_wr),
    .frame_raddr   (frame_raddr),
    .frame_rdata   (frame_rdata),
    .scratch_wr    (scratch_wr),
    .scratch_raddr (scratch_raddr),
    .scratch_rdata (scratch_rdata)
  );

  chbr_ram #(
    .WIDTH (CH_W),
    .DEPTH (FRAME_CHANNELS)
  ) u_frame_ram (
    .clk   (clk),
    .we    (frame_wr.we),
    .waddr (frame_wr.addr),
    .wdata (frame_wr.data),
    .raddr (frame_raddr),
    .rdata (frame_rdata)
  );

  chbr_ram #(
    .WIDTH (CH_W),
    .DEPTH (SCRATCH_DEPTH)
  ) u_scratch_ram (
    .clk   (clk),
    .we    (scratch_wr.we),
    .waddr (scratch_wr.addr),
    .wdata (scratch_wr.data),
    .raddr (scratch_raddr),
    .rdata (scratch_rdata)
  );

endmodule
